>>> sv/assert_macros.svh
// Assertion macros shared by the RTL files; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent check on an explicit clock and reset.
`define JSU_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Same check using the clk and rst of the enclosing module.
`define JSU_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`else

`define JSU_ASSERT(lbl, ck, rs, prop, msg)
`define JSU_CHECK(lbl, prop, msg)

`endif

`endif

>>> sv/jsu_pkg.sv
// Types, character codes and UTF-8 encoder for the JSON string unescaper.
package jsu_pkg;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_OK    = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;

  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  localparam logic [1:0] LAST_HEX = 2'd3;

  // Up to three results caused by one input byte; a non-data kind always
  // comes alone.
  typedef struct packed {
    logic [1:0]      cnt;
    kind_t           kind;
    logic [2:0][7:0] bytes;
  } bundle_t;

  function automatic bundle_t utf8_enc(input logic [15:0] cp);
    bundle_t b;
    b = '0;
    b.kind = KIND_DATA;
    if (cp < 16'h0080) begin
      b.cnt = 2'd1;
      b.bytes[0] = cp[7:0];
    end else if (cp < 16'h0800) begin
      b.cnt = 2'd2;
      b.bytes[0] = {3'b110, cp[10:6]};
      b.bytes[1] = {2'b10, cp[5:0]};
    end else begin
      b.cnt = 2'd3;
      b.bytes[0] = {4'b1110, cp[15:12]};
      b.bytes[1] = {2'b10, cp[11:6]};
      b.bytes[2] = {2'b10, cp[5:0]};
    end
    return b;
  endfunction

endpackage

>>> sv/jsu_decode.sv
// Escape decoder: string state registers and per-byte result bundle logic.
`include "assert_macros.svh"

module jsu_decode (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [7:0]       c,
  output jsu_pkg::bundle_t res
);
  import jsu_pkg::*;

  logic        escape_pending, escape_pending_next;
  logic        in_unicode, in_unicode_next;
  logic [1:0]  hex_digits_seen, hex_digits_seen_next;
  logic [15:0] code_point, code_point_next;
  logic        error_latched, error_latched_next;

  logic        hex_ok;
  logic [3:0]  hex_v;
  logic [15:0] cp_shift;
  logic        ordinary;

  always_comb begin
    hex_ok = 1'b1;
    hex_v  = c[3:0];
    if (c inside {[CH_0:CH_9]}) begin
      hex_v = c[3:0];
    end else if (c inside {[CH_UA:CH_UF], [CH_LA:CH_LF]}) begin
      hex_v = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp_shift = {code_point[11:0], hex_v};

  always_comb begin
    escape_pending_next  = escape_pending;
    in_unicode_next      = in_unicode;
    hex_digits_seen_next = hex_digits_seen;
    code_point_next      = code_point;
    error_latched_next   = error_latched;
    res                  = '0;
    res.kind             = KIND_DATA;
    ordinary             = 1'b1;

    if (c == CH_NUL) begin
      escape_pending_next  = 1'b0;
      in_unicode_next      = 1'b0;
      hex_digits_seen_next = '0;
      code_point_next      = '0;
      error_latched_next   = 1'b0;
      res.cnt              = 2'd1;
      res.kind             = KIND_ERROR;
      ordinary             = 1'b0;
    end else begin
      if (in_unicode) begin
        if (!hex_ok) begin
          error_latched_next   = 1'b1;
          in_unicode_next      = 1'b0;
          hex_digits_seen_next = '0;
          code_point_next      = '0;
        end else begin
          ordinary = 1'b0;
          if (hex_digits_seen == LAST_HEX) begin
            res                  = utf8_enc(cp_shift);
            in_unicode_next      = 1'b0;
            hex_digits_seen_next = '0;
            code_point_next      = '0;
          end else begin
            hex_digits_seen_next = hex_digits_seen + 2'd1;
            code_point_next      = cp_shift;
          end
        end
      end else if (escape_pending) begin
        ordinary            = 1'b0;
        escape_pending_next = 1'b0;
        case (c)
          CH_QUOTE, CH_BSLASH, CH_SLASH: begin
            res.cnt = 2'd1;
            res.bytes[0] = c;
          end
          CH_B: begin
            res.cnt = 2'd1;
            res.bytes[0] = CTL_BS;
          end
          CH_F: begin
            res.cnt = 2'd1;
            res.bytes[0] = CTL_FF;
          end
          CH_N: begin
            res.cnt = 2'd1;
            res.bytes[0] = CTL_LF;
          end
          CH_R: begin
            res.cnt = 2'd1;
            res.bytes[0] = CTL_CR;
          end
          CH_T: begin
            res.cnt = 2'd1;
            res.bytes[0] = CTL_HT;
          end
          CH_U: begin
            in_unicode_next      = 1'b1;
            hex_digits_seen_next = '0;
            code_point_next      = '0;
          end
          default: begin
          end
        endcase
      end

      if (ordinary) begin
        if (c == CH_QUOTE) begin
          res.cnt              = 2'd1;
          res.kind             = error_latched_next ? KIND_ERROR : KIND_OK;
          escape_pending_next  = 1'b0;
          in_unicode_next      = 1'b0;
          hex_digits_seen_next = '0;
          code_point_next      = '0;
          error_latched_next   = 1'b0;
        end else if (c == CH_BSLASH) begin
          escape_pending_next = 1'b1;
        end else begin
          res.cnt      = 2'd1;
          res.bytes[0] = c;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending  <= 1'b0;
      in_unicode      <= 1'b0;
      hex_digits_seen <= '0;
      code_point      <= '0;
      error_latched   <= 1'b0;
    end else if (fire) begin
      escape_pending  <= escape_pending_next;
      in_unicode      <= in_unicode_next;
      hex_digits_seen <= hex_digits_seen_next;
      code_point      <= code_point_next;
      error_latched   <= error_latched_next;
    end
  end

  `JSU_CHECK(a_end_clears, fire && res.kind != KIND_DATA |=> !escape_pending && !in_unicode && !error_latched, "state not cleared at end of string")
  `JSU_CHECK(a_uni_no_esc, in_unicode |-> !escape_pending, "escape pending inside unicode escape")
  `JSU_CHECK(a_end_alone, res.kind != KIND_DATA |-> res.cnt == 2'd1, "end status not a single result")

endmodule

>>> sv/jsu_serial.sv
// Result register: holds one bundle and hands its bytes out one per request.
`include "assert_macros.svh"

module jsu_serial (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  jsu_pkg::bundle_t bin,
  output logic             free,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic [1:0]       kind,
  output logic             last
);
  import jsu_pkg::*;

  logic [1:0]      cnt;
  logic [1:0]      idx;
  kind_t           knd;
  logic [2:0][7:0] bytes;
  logic            take;

  assign out_valid = (cnt != 2'd0);
  assign last      = (idx == cnt - 2'd1);
  assign take      = out_valid && !out_stall;
  assign free      = !out_valid || (take && last);
  assign out_byte  = bytes[idx];
  assign kind      = knd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (load) begin
      cnt <= bin.cnt;
      idx <= '0;
    end else if (take) begin
      if (last) begin
        cnt <= '0;
        idx <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      knd   <= bin.kind;
      bytes <= bin.bytes;
    end
  end

  `JSU_ASSERT(a_idx_range, clk, rst, out_valid |-> idx < cnt, "result index beyond bundle")
  `JSU_ASSERT(a_load_free, clk, rst, load |-> free, "bundle overwritten before drained")
  `JSU_CHECK(a_status_last, out_valid && knd != KIND_DATA |-> last && idx == 2'd0, "end status not alone")

endmodule

>>> sv/json_string_unescaper.sv
// Top level of the JSON string unescaper: input register, decoder, result serializer.
// An accepted byte is held in the input register; its decoded results are loaded
// into the result register once that is free, and are handed out from there.
// Throughput: one byte per cycle while out_stall is low and each byte gives at most
// one result; a multi-byte UTF-8 result holds the input until its last byte is taken.
// Reset (rst, synchronous) empties both registers and clears all string state.
module json_string_unescaper (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic       last
);
  import jsu_pkg::*;

  logic       in_full;
  logic [7:0] inb;
  logic       free;
  logic       move;
  logic       accept;
  bundle_t    res;

  assign move     = in_full && free;
  assign in_stall = in_full && !free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      inb <= in_byte;
    end
  end

  jsu_decode u_decode (
    .clk  (clk),
    .rst  (rst),
    .fire (move),
    .c    (inb),
    .res  (res)
  );

  jsu_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .load      (move),
    .bin       (res),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .kind      (kind),
    .last      (last)
  );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the JSON string unescaper: random escape/UTF-8 traffic with stalls.
`timescale 1ns / 1ps

module testbench;
  import jsu_pkg::*;

  localparam int HEX_DIGITS   = 4;
  localparam int RANDOM_ITEMS = 200;
  localparam int HOLD_CYCLES  = 150;
  localparam int CYCLE_LIMIT  = 100000;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } result_t;

  class decode_scoreboard;
    bit         esc_pending;
    bit         in_uni;
    int         hex_cnt;
    logic [15:0] cp;
    bit         err_latched;
    result_t    expected[$];
    result_t    batch[$];
    int         errors;

    function new();
      clear_string();
      errors = 0;
    endfunction

    function void clear_string();
      esc_pending = 1'b0;
      in_uni      = 1'b0;
      hex_cnt     = 0;
      cp          = '0;
      err_latched = 1'b0;
    endfunction

    static function int hex_value(logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
      if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
      if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
      return -1;
    endfunction

    function void add(logic [7:0] b, kind_t k);
      result_t r;
      r.data = b;
      r.kind = k;
      r.last = 1'b0;
      batch.push_back(r);
    endfunction

    function void add_utf8(logic [15:0] v);
      if (v < 16'h0080) begin
        add(v[7:0], KIND_DATA);
      end else if (v < 16'h0800) begin
        add({3'b110, v[10:6]}, KIND_DATA);
        add({2'b10, v[5:0]}, KIND_DATA);
      end else begin
        add({4'b1110, v[15:12]}, KIND_DATA);
        add({2'b10, v[11:6]}, KIND_DATA);
        add({2'b10, v[5:0]}, KIND_DATA);
      end
    endfunction

    // Decode one accepted request and queue the results it should produce.
    function void note_request(logic [7:0] c);
      int    v;
      bit    plain;
      kind_t k;
      batch.delete();
      plain = 1'b1;
      if (c == CH_NUL) begin
        clear_string();
        add(8'h00, KIND_ERROR);
      end else begin
        if (in_uni) begin
          v = hex_value(c);
          plain = 1'b0;
          if (v < 0) begin
            err_latched = 1'b1;
            in_uni  = 1'b0;
            hex_cnt = 0;
            cp      = '0;
            plain   = 1'b1;
          end else begin
            cp = {cp[11:0], v[3:0]};
            hex_cnt++;
            if (hex_cnt == HEX_DIGITS) begin
              add_utf8(cp);
              in_uni  = 1'b0;
              hex_cnt = 0;
              cp      = '0;
            end
          end
        end else if (esc_pending) begin
          plain = 1'b0;
          esc_pending = 1'b0;
          case (c)
            CH_QUOTE:  add(CH_QUOTE, KIND_DATA);
            CH_BSLASH: add(CH_BSLASH, KIND_DATA);
            CH_SLASH:  add(CH_SLASH, KIND_DATA);
            CH_B:      add(CTL_BS, KIND_DATA);
            CH_F:      add(CTL_FF, KIND_DATA);
            CH_N:      add(CTL_LF, KIND_DATA);
            CH_R:      add(CTL_CR, KIND_DATA);
            CH_T:      add(CTL_HT, KIND_DATA);
            CH_U: begin
              in_uni  = 1'b1;
              hex_cnt = 0;
              cp      = '0;
            end
            default: ;
          endcase
        end
        if (plain) begin
          if (c == CH_QUOTE) begin
            k = err_latched ? KIND_ERROR : KIND_OK;
            clear_string();
            add(8'h00, k);
          end else if (c == CH_BSLASH) begin
            esc_pending = 1'b1;
          end else begin
            add(c, KIND_DATA);
          end
        end
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) expected.push_back(batch[i]);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void check_result(logic [7:0] b, logic [1:0] k, logic l);
      result_t e;
      if (expected.size() == 0) begin
        flag($sformatf("unexpected result byte=%02h kind=%0d last=%0b", b, k, l));
        return;
      end
      e = expected.pop_front();
      if (b !== e.data || k !== e.kind || l !== e.last)
        flag($sformatf("mismatch: expected byte=%02h kind=%0d last=%0b, got byte=%02h kind=%0d last=%0b",
                       e.data, e.kind, e.last, b, k, l));
    endfunction

    function int outstanding();
      return expected.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  decode_scoreboard sb;
  bit  quiet;
  bit  hold_req;
  int  sent_random;
  int  cycle_count;

  json_string_unescaper dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .kind      (kind),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_byte, kind, last);
  end

  // Result side: random stalls, a quiet stretch, and one long hold-off.
  initial begin
    int  hold_left;
    bit  take_hold;
    bit  calm;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      take_hold = hold_req;
      calm = quiet;
      @(negedge clk);
      if (take_hold) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_stall = 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
      end else if (calm) begin
        out_stall = 1'b0;
      end else begin
        out_stall = ($urandom_range(0, 99) < 28);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 99) < 15) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    do @(posedge clk); while (in_stall);
    sb.note_request(b);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
    if (n < 4'd10) return CH_0 + 8'(n);
    return (upper ? CH_UA : CH_LA) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] pick_escape(int i);
    case (i)
      0: return CH_QUOTE;
      1: return CH_BSLASH;
      2: return CH_SLASH;
      3: return CH_B;
      4: return CH_F;
      5: return CH_N;
      6: return CH_R;
      default: return CH_T;
    endcase
  endfunction

  task automatic random_string();
    logic [7:0]  text[$];
    logic [15:0] v;
    logic [7:0]  c;
    int          pieces;
    int          r;
    int          nd;
    pieces = $urandom_range(0, 8);
    for (int p = 0; p < pieces; p++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
        text.push_back(c);
      end else if (r < 65) begin
        text.push_back(CH_BSLASH);
        text.push_back(pick_escape($urandom_range(0, 7)));
      end else if (r < 85) begin
        case ($urandom_range(0, 2))
          0: v = 16'($urandom_range(0, 16'h007F));
          1: v = 16'($urandom_range(16'h0080, 16'h07FF));
          default: v = 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
        text.push_back(CH_BSLASH);
        text.push_back(CH_U);
        for (int d = 3; d >= 0; d--)
          text.push_back(hex_char(v[d*4 +: 4], 1'($urandom_range(0, 1))));
      end else if (r < 92) begin
        do c = 8'($urandom_range(1, 255));
        while (c inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
        text.push_back(CH_BSLASH);
        text.push_back(c);
      end else begin
        nd = $urandom_range(0, 3);
        text.push_back(CH_BSLASH);
        text.push_back(CH_U);
        for (int d = 0; d < nd; d++)
          text.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
        do c = 8'($urandom_range(0, 255)); while (decode_scoreboard::hex_value(c) >= 0);
        text.push_back(c);
      end
    end
    r = $urandom_range(0, 99);
    if (r < 88) text.push_back(CH_QUOTE);
    else if (r < 94) text.push_back(CH_NUL);
    foreach (text[i]) begin
      send_byte(text[i]);
      sent_random++;
    end
  endtask

  initial begin
    logic [7:0] directed[$];
    bit         held;
    bit         paused;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'h00;
    quiet = 1'b0;
    hold_req = 1'b0;
    sent_random = 0;
    held = 1'b0;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // extremes, \u0000, mixed-case \uFFFF, unknown escape, bad hex ending on a
    // quote, NUL right after a backslash, clean close
    directed = '{8'hFF, 8'h01,
                 CH_BSLASH, CH_U, CH_0, CH_0, CH_0, CH_0,
                 CH_BSLASH, CH_U, CH_UF, CH_LF, CH_UF, CH_LF,
                 CH_BSLASH, 8'h71,
                 CH_BSLASH, CH_U, 8'h31, CH_QUOTE,
                 CH_BSLASH, CH_NUL,
                 8'h41, CH_QUOTE};
    foreach (directed[i]) send_byte(directed[i]);
    wait_drained();

    while (sent_random < RANDOM_ITEMS) begin
      if (sent_random >= 40 && !held) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      quiet = (sent_random >= 90 && sent_random < 150);
      if (sent_random >= 170 && !paused) begin
        wait_drained();
        paused = 1'b1;
      end
      random_string();
    end
    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
